>>> design/orfs_pkg.sv
// Shared types, codes and defaults for the ORF stop scanner.
package orfs_pkg;

    localparam int unsigned POSITION_BITS_DEF = 16;

    localparam logic [7:0] STOP_CODE = 8'h2A;
    localparam logic [7:0] MET_CODE  = 8'h4D;

    localparam int unsigned CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_ORF_LENGTH        = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_ORF_ENABLE      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_METHIONINE_START_MODE = 2'd2;

    localparam logic [15:0] MIN_LEN_RESET = 16'd1;

    typedef struct packed {
        logic [7:0] residue;
        logic       last_in_frame;
        logic       stop_was_appended;
    } t_orfs_in;

    typedef struct packed {
        logic        orf_found;
        logic [15:0] orf_start;
        logic [15:0] orf_end;
        logic [15:0] orf_length;
        logic [15:0] orf_number;
        logic        frame_done;
        logic [15:0] frame_total;
        logic        position_overflow;
    } t_orfs_out;

    // Handshake between the scan core and the result register.
    typedef struct packed {
        logic fire;
        logic emit;
    } t_orfs_res_ctl;

endpackage

>>> design/orf_stop_scanner.sv
// ORF stop scanner top level: input register, scan core, result register.
// An accepted residue beat is held in the input register, then its result in the result register.
// Throughput: one residue per cycle while the output is not stalled.
// Residues that close no ORF and do not end the frame give no result beat.
// Synchronous active-low reset clears frame state and loads register defaults.
module orf_stop_scanner #(
    parameter int unsigned POSITION_BITS = orfs_pkg::POSITION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  orfs_pkg::t_orfs_in                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output orfs_pkg::t_orfs_out               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [orfs_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);

    logic                    in_valid;
    orfs_pkg::t_orfs_in      in_data;
    logic                    res_ready;
    orfs_pkg::t_orfs_res_ctl res_ctl;
    orfs_pkg::t_orfs_out     res;

    assign o_cfg_ready = 1'b1;

    orfs_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .i_take  (res_ready),
        .o_valid (in_valid),
        .o_data  (in_data)
    );

    orfs_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (in_valid),
        .i_data      (in_data),
        .i_res_ready (res_ready),
        .o_ctl       (res_ctl),
        .o_res       (res)
    );

    orfs_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (res_ctl),
        .i_res   (res),
        .o_ready (res_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

>>> design/orfs_in_stage.sv
// Input register: holds one residue beat until the scan core consumes it.
module orfs_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  orfs_pkg::t_orfs_in i_data,
    input  logic              i_take,
    output logic              o_valid,
    output orfs_pkg::t_orfs_in o_data
);

    logic               r_valid;
    orfs_pkg::t_orfs_in r_data;

    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

>>> design/orfs_core.sv
// Scan core: configuration, frame state and per-residue ORF decision.
module orfs_core #(
    parameter int unsigned POSITION_BITS = orfs_pkg::POSITION_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [orfs_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [15:0]                          i_cfg_data,
    input  logic                                 i_valid,
    input  orfs_pkg::t_orfs_in                   i_data,
    input  logic                                 i_res_ready,
    output orfs_pkg::t_orfs_res_ctl              o_ctl,
    output orfs_pkg::t_orfs_out                  o_res
);

    localparam int unsigned W = (POSITION_BITS > 16) ? POSITION_BITS : 16;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [15:0] r_min_len;
    logic        r_first_en;
    logic        r_met_mode;

    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_seg_start;
    logic                     r_stop_seen;
    logic                     r_prev_stop;
    logic [POSITION_BITS-1:0] r_met_pos;
    logic                     r_met_valid;
    logic [15:0]              r_count;
    logic                     r_ovf;

    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] n_seg_start;
    logic                     n_stop_seen;
    logic                     n_prev_stop;
    logic [POSITION_BITS-1:0] n_met_pos;
    logic                     n_met_valid;
    logic [15:0]              n_count;
    logic                     n_ovf;

    logic                     fire;
    logic                     is_stop;
    logic                     at_max;
    logic [15:0]              min_len;
    logic [POSITION_BITS-1:0] seg;
    logic [POSITION_BITS-1:0] met_len;
    logic [POSITION_BITS-1:0] base_len;
    logic [POSITION_BITS-1:0] len;
    logic                     found;
    logic                     reaches_min;
    logic [W-1:0]             start_w;
    logic [W-1:0]             end_w;
    logic [W-1:0]             len_w;
    logic [15:0]              count_inc;

    assign fire    = i_valid && i_res_ready;
    assign is_stop = (i_data.residue == orfs_pkg::STOP_CODE);
    assign at_max  = (r_pos == POS_MAX);
    assign min_len = (r_min_len == 16'd0) ? 16'd1 : r_min_len;

    assign seg      = (r_seg_start < r_pos) ? r_pos - r_seg_start : '0;
    assign met_len  = (r_met_valid && (r_met_pos < r_pos)) ? r_pos - r_met_pos : '0;
    assign base_len = r_met_mode ? met_len : seg;
    assign reaches_min = (W'(base_len) >= W'(min_len));

    always_comb begin
        found = 1'b0;
        len   = base_len;
        if (is_stop && !r_prev_stop) begin
            if (reaches_min) begin
                found = 1'b1;
            end else if (!r_stop_seen && r_first_en && (r_pos != '0)) begin
                len   = seg;
                found = (seg != '0);
            end else if (i_data.last_in_frame && i_data.stop_was_appended) begin
                found = (base_len != '0);
            end
        end
    end

    assign count_inc = (found && (r_count != 16'hFFFF)) ? r_count + 16'd1 : r_count;
    assign start_w   = W'(r_pos - len);
    assign end_w     = W'(r_pos) - {{(W-1){1'b0}}, 1'b1};
    assign len_w     = W'(len);

    always_comb begin
        n_pos       = at_max ? r_pos : r_pos + {{(POSITION_BITS-1){1'b0}}, 1'b1};
        n_ovf       = r_ovf || at_max;
        n_count     = count_inc;
        n_seg_start = r_seg_start;
        n_stop_seen = r_stop_seen;
        n_prev_stop = is_stop;
        n_met_pos   = r_met_pos;
        n_met_valid = r_met_valid;
        if (is_stop) begin
            n_seg_start = n_pos;
            n_met_valid = 1'b0;
            if (!r_prev_stop) begin
                n_stop_seen = 1'b1;
            end
        end else if ((i_data.residue == orfs_pkg::MET_CODE) && !r_met_valid) begin
            n_met_pos   = r_pos;
            n_met_valid = 1'b1;
        end
    end

    always_comb begin
        o_res.orf_found         = found;
        o_res.orf_start         = found ? start_w[15:0] : 16'd0;
        o_res.orf_end           = found ? end_w[15:0] : 16'd0;
        o_res.orf_length        = found ? len_w[15:0] : 16'd0;
        o_res.orf_number        = found ? count_inc : 16'd0;
        o_res.frame_done        = i_data.last_in_frame;
        o_res.frame_total       = count_inc;
        o_res.position_overflow = n_ovf;
        o_ctl.fire              = fire;
        o_ctl.emit              = found || i_data.last_in_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len  <= orfs_pkg::MIN_LEN_RESET;
            r_first_en <= 1'b0;
            r_met_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                orfs_pkg::CFG_MIN_ORF_LENGTH:        r_min_len  <= i_cfg_data;
                orfs_pkg::CFG_FIRST_ORF_ENABLE:      r_first_en <= i_cfg_data[0];
                orfs_pkg::CFG_METHIONINE_START_MODE: r_met_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && i_data.last_in_frame)) begin
            r_pos       <= '0;
            r_seg_start <= '0;
            r_stop_seen <= 1'b0;
            r_prev_stop <= 1'b0;
            r_met_pos   <= '0;
            r_met_valid <= 1'b0;
            r_count     <= 16'd0;
            r_ovf       <= 1'b0;
        end else if (fire) begin
            r_pos       <= n_pos;
            r_seg_start <= n_seg_start;
            r_stop_seen <= n_stop_seen;
            r_prev_stop <= n_prev_stop;
            r_met_pos   <= n_met_pos;
            r_met_valid <= n_met_valid;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
        end
    end

endmodule

>>> design/orfs_out_stage.sv
// Result register: holds one result beat until the consumer takes it.
module orfs_out_stage (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  orfs_pkg::t_orfs_res_ctl i_ctl,
    input  orfs_pkg::t_orfs_out     i_res,
    output logic                    o_ready,
    output logic                    o_valid,
    input  logic                    i_stall,
    output orfs_pkg::t_orfs_out     o_data
);

    logic                r_valid;
    orfs_pkg::t_orfs_out r_data;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_ctl.fire && i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.fire && i_ctl.emit) begin
            r_data <= i_res;
        end
    end

endmodule
